// File: sv/gte_pkg.sv
// ----------------------------------------------------------------------------
// gte_pkg
// shared types, constants and helper functions of the geodetic to enu block
// ----------------------------------------------------------------------------
package gte_pkg;

   localparam int CORDIC_STEPS = 32;
   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [1:0] ACT_CONVERT = 2'd0;
   localparam logic [1:0] ACT_REBASE  = 2'd1;
   localparam logic [1:0] ACT_RELOAD  = 2'd2;
   localparam logic [1:0] ACT_SPARE   = 2'd3;

   localparam logic [2:0] CSR_REF_LAT = 3'd0;
   localparam logic [2:0] CSR_REF_LON = 3'd1;
   localparam logic [2:0] CSR_REF_ALT = 3'd2;
   localparam logic [2:0] CSR_SEMI    = 3'd3;
   localparam logic [2:0] CSR_ECC     = 3'd4;

   localparam logic [32:0] SEMI_RESET = 33'd6378137000;
   localparam logic [26:0] ECC_RESET  = 27'd28752143;

   localparam logic signed [47:0] OUT_LIMIT = 48'sd17179869184;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LAT, ST_LON, ST_SQ, ST_TE, ST_ROOT, ST_DIV, ST_NZ, ST_RC,
      ST_PX, ST_PY, ST_PZ, ST_BLAT, ST_BLON, ST_XC, ST_YS, ST_YC, ST_XS,
      ST_ZC, ST_RS, ST_ZS, ST_RCL, ST_OUT
   } state_type;

   typedef enum logic {DSU_SQRT, DSU_DIV} dsu_op_type;

   function automatic logic [29:0] atan_bam(input logic [5:0] idx);
      logic [29:0] v;
      case (idx)
         6'd0:  v = 30'd536870912;
         6'd1:  v = 30'd316933406;
         6'd2:  v = 30'd167458907;
         6'd3:  v = 30'd85004756;
         6'd4:  v = 30'd42667331;
         6'd5:  v = 30'd21354465;
         6'd6:  v = 30'd10679838;
         6'd7:  v = 30'd5340245;
         6'd8:  v = 30'd2670163;
         6'd9:  v = 30'd1335087;
         6'd10: v = 30'd667544;
         6'd11: v = 30'd333772;
         6'd12: v = 30'd166886;
         6'd13: v = 30'd83443;
         6'd14: v = 30'd41722;
         6'd15: v = 30'd20861;
         6'd16: v = 30'd10430;
         6'd17: v = 30'd5215;
         6'd18: v = 30'd2608;
         6'd19: v = 30'd1304;
         6'd20: v = 30'd652;
         6'd21: v = 30'd326;
         6'd22: v = 30'd163;
         6'd23: v = 30'd81;
         6'd24: v = 30'd41;
         6'd25: v = 30'd20;
         6'd26: v = 30'd10;
         6'd27: v = 30'd5;
         6'd28: v = 30'd3;
         6'd29: v = 30'd1;
         6'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [35:0] sat_out(input logic signed [47:0] v);
      logic signed [35:0] r;
      if (v > OUT_LIMIT) begin
         r = 36'(OUT_LIMIT);
      end else if (v < -OUT_LIMIT) begin
         r = 36'(-OUT_LIMIT);
      end else begin
         r = 36'(v);
      end
      return r;
   endfunction

endpackage

// File: sv/geodetic_to_local_enu.sv
// ----------------------------------------------------------------------------
// geodetic_to_local_enu
// latitude, longitude, altitude to east, north, up offsets from a stored base
// ----------------------------------------------------------------------------
// one beat at a time: the input is stalled from acceptance until the result
// is loaded into the output register, and further while the output stalls;
// a rebase or reload stops after the ecef point and skips the enu rotation;
// the time is set by the serial cordic, the shift and subtract unit and the
// two-pass 41x32 multiplier
// synchronous reset clears control, registers to their defaults, base to zero
module geodetic_to_local_enu (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic signed [31:0]  req_fix_latitude,
   input  logic signed [31:0]  req_fix_longitude,
   input  logic signed [27:0]  req_fix_altitude,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [35:0]  rsp_east,
   output logic signed [35:0]  rsp_north,
   output logic signed [35:0]  rsp_up,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [32:0]         csr_data
);

   gte_pkg::state_type state_ff, state_in;
   logic issued_ff, issued_in;

   logic [31:0] cfg_lat_ff, cfg_lon_ff;
   logic [27:0] cfg_alt_ff;
   logic [32:0] cfg_semi_ff;
   logic [26:0] cfg_ecc_ff;

   logic [1:0] op_act_ff;
   logic [31:0] op_lat_ff, op_lon_ff;
   logic signed [27:0] op_alt_ff;

   logic [31:0] base_lat_ff, base_lon_ff;
   logic signed [35:0] base_x_ff, base_y_ff, base_z_ff;

   logic signed [32:0] sl_ff, cl_ff, so_ff, co_ff;
   logic [31:0] s2_ff, t_ff, w_ff;
   logic [35:0] n_ff, nz_ff;
   logic signed [40:0] rc_ff, r_ff;
   logic signed [36:0] px_ff, py_ff;
   logic signed [44:0] acc_ff;
   logic signed [35:0] east_ff, north_ff, up_ff;

   logic rsp_valid_ff;
   logic signed [35:0] rsp_east_ff, rsp_north_ff, rsp_up_ff;

   logic accept, is_base;

   // shared multiplier
   logic mul_start, mul_done_ff;
   logic [1:0] mul_phase_ff;
   logic [40:0] mul_a_ff;
   logic [31:0] mul_b_ff, mop_a;
   logic [63:0] mprod;
   logic [42:0] mul_ph_ff;
   logic [61:0] mul_pl_ff;
   logic [72:0] mul_p_ff;

   logic signed [40:0] opa, mag_a_s;
   logic signed [32:0] opb, mag_b_s;
   logic neg;
   logic [73:0] p_r30, p_r32;
   logic signed [44:0] res;
   logic signed [40:0] nh, nzh, dx, dy, dz;

   logic cor_start, cor_done;
   logic [31:0] cor_angle;
   logic signed [32:0] cor_sin, cor_cos;

   logic dsu_start, dsu_done;
   gte_pkg::dsu_op_type dsu_op;
   logic [63:0] dsu_arg, dsu_result;

   assign accept = req_valid && !req_stall;
   assign req_stall = state_ff != gte_pkg::ST_IDLE;
   assign is_base = (op_act_ff == gte_pkg::ACT_REBASE) || (op_act_ff == gte_pkg::ACT_RELOAD);

   gte_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (cor_angle),
      .done    (cor_done),
      .sin_out (cor_sin),
      .cos_out (cor_cos)
   );

   gte_dsu u_dsu (
      .clock   (clock),
      .reset   (reset),
      .start   (dsu_start),
      .op      (dsu_op),
      .arg     (dsu_arg),
      .divisor (w_ff),
      .done    (dsu_done),
      .result  (dsu_result)
   );

   // operand selection
   always_comb begin
      nh = $signed({5'b0, n_ff}) + 41'(op_alt_ff);
      nzh = $signed({5'b0, nz_ff}) + 41'(op_alt_ff);
      dx = 41'(px_ff) - 41'(base_x_ff);
      dy = 41'(py_ff) - 41'(base_y_ff);
      dz = 41'(acc_ff) - 41'(base_z_ff);
      opa = '0;
      opb = '0;
      case (state_ff)
         gte_pkg::ST_SQ:  begin opa = 41'(sl_ff); opb = sl_ff; end
         gte_pkg::ST_TE:  begin opa = $signed({14'b0, cfg_ecc_ff}); opb = $signed({1'b0, s2_ff}); end
         gte_pkg::ST_NZ:  begin opa = $signed({5'b0, n_ff}); opb = $signed({6'b0, cfg_ecc_ff}); end
         gte_pkg::ST_RC:  begin opa = nh; opb = cl_ff; end
         gte_pkg::ST_PX:  begin opa = rc_ff; opb = co_ff; end
         gte_pkg::ST_PY:  begin opa = rc_ff; opb = so_ff; end
         gte_pkg::ST_PZ:  begin opa = nzh; opb = sl_ff; end
         gte_pkg::ST_XC:  begin opa = dx; opb = co_ff; end
         gte_pkg::ST_YS:  begin opa = dy; opb = so_ff; end
         gte_pkg::ST_YC:  begin opa = dy; opb = co_ff; end
         gte_pkg::ST_XS:  begin opa = dx; opb = so_ff; end
         gte_pkg::ST_ZC:  begin opa = 41'($signed(nz_ff)); opb = cl_ff; end
         gte_pkg::ST_RS:  begin opa = r_ff; opb = sl_ff; end
         gte_pkg::ST_ZS:  begin opa = 41'($signed(nz_ff)); opb = sl_ff; end
         gte_pkg::ST_RCL: begin opa = r_ff; opb = cl_ff; end
         default: begin opa = '0; opb = '0; end
      endcase
      mag_a_s = opa[40] ? -opa : opa;
      mag_b_s = opb[32] ? -opb : opb;
      neg = opa[40] ^ opb[32];
      p_r30 = {1'b0, mul_p_ff} + 74'd536870912;
      p_r32 = {1'b0, mul_p_ff} + 74'd2147483648;
      res = neg ? -$signed({1'b0, p_r30[73:30]}) : $signed({1'b0, p_r30[73:30]});
   end

   // multiplier: high and low partial products, then sum
   always_comb begin
      mop_a = (mul_phase_ff == 2'd1) ? {21'b0, mul_a_ff[40:30]} : {2'b0, mul_a_ff[29:0]};
      mprod = mop_a * mul_b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_phase_ff <= 2'd0;
         mul_done_ff <= 1'b0;
      end else begin
         mul_done_ff <= 1'b0;
         case (mul_phase_ff)
            2'd0: if (mul_start) mul_phase_ff <= 2'd1;
            2'd1: mul_phase_ff <= 2'd2;
            2'd2: mul_phase_ff <= 2'd3;
            default: begin
               mul_phase_ff <= 2'd0;
               mul_done_ff <= 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         mul_a_ff <= mag_a_s;
         mul_b_ff <= mag_b_s[31:0];
      end
      if (mul_phase_ff == 2'd1) mul_ph_ff <= mprod[42:0];
      if (mul_phase_ff == 2'd2) mul_pl_ff <= mprod[61:0];
      if (mul_phase_ff == 2'd3) mul_p_ff <= (73'(mul_ph_ff) << 30) + 73'(mul_pl_ff);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      issued_in = issued_ff;
      mul_start = 1'b0;
      cor_start = 1'b0;
      dsu_start = 1'b0;
      cor_angle = op_lat_ff;
      dsu_op = gte_pkg::DSU_SQRT;
      dsu_arg = {3'b0, 33'h1_0000_0000 - {1'b0, t_ff}, 28'b0};
      case (state_ff)
         gte_pkg::ST_IDLE: begin
            issued_in = 1'b0;
            if (accept) state_in = gte_pkg::ST_LAT;
         end
         gte_pkg::ST_LAT, gte_pkg::ST_LON, gte_pkg::ST_BLAT, gte_pkg::ST_BLON: begin
            case (state_ff)
               gte_pkg::ST_LON:  cor_angle = op_lon_ff;
               gte_pkg::ST_BLAT: cor_angle = base_lat_ff;
               gte_pkg::ST_BLON: cor_angle = base_lon_ff;
               default:          cor_angle = op_lat_ff;
            endcase
            cor_start = !issued_ff;
            issued_in = 1'b1;
            if (cor_done) begin
               issued_in = 1'b0;
               case (state_ff)
                  gte_pkg::ST_LAT:  state_in = gte_pkg::ST_LON;
                  gte_pkg::ST_LON:  state_in = gte_pkg::ST_SQ;
                  gte_pkg::ST_BLAT: state_in = gte_pkg::ST_BLON;
                  default:          state_in = gte_pkg::ST_XC;
               endcase
            end
         end
         gte_pkg::ST_ROOT, gte_pkg::ST_DIV: begin
            if (state_ff == gte_pkg::ST_DIV) begin
               dsu_op = gte_pkg::DSU_DIV;
               dsu_arg = {1'b0, cfg_semi_ff, 30'b0} + 64'(w_ff >> 1);
            end
            dsu_start = !issued_ff;
            issued_in = 1'b1;
            if (dsu_done) begin
               issued_in = 1'b0;
               state_in = (state_ff == gte_pkg::ST_ROOT) ? gte_pkg::ST_DIV : gte_pkg::ST_NZ;
            end
         end
         gte_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = gte_pkg::ST_IDLE;
         end
         default: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done_ff) begin
               issued_in = 1'b0;
               case (state_ff)
                  gte_pkg::ST_SQ:  state_in = gte_pkg::ST_TE;
                  gte_pkg::ST_TE:  state_in = gte_pkg::ST_ROOT;
                  gte_pkg::ST_NZ:  state_in = gte_pkg::ST_RC;
                  gte_pkg::ST_RC:  state_in = gte_pkg::ST_PX;
                  gte_pkg::ST_PX:  state_in = gte_pkg::ST_PY;
                  gte_pkg::ST_PY:  state_in = gte_pkg::ST_PZ;
                  gte_pkg::ST_PZ:  state_in = is_base ? gte_pkg::ST_OUT : gte_pkg::ST_BLAT;
                  gte_pkg::ST_XC:  state_in = gte_pkg::ST_YS;
                  gte_pkg::ST_YS:  state_in = gte_pkg::ST_YC;
                  gte_pkg::ST_YC:  state_in = gte_pkg::ST_XS;
                  gte_pkg::ST_XS:  state_in = gte_pkg::ST_ZC;
                  gte_pkg::ST_ZC:  state_in = gte_pkg::ST_RS;
                  gte_pkg::ST_RS:  state_in = gte_pkg::ST_ZS;
                  gte_pkg::ST_ZS:  state_in = gte_pkg::ST_RCL;
                  default:         state_in = gte_pkg::ST_OUT;
               endcase
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gte_pkg::ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         issued_ff <= issued_in;
      end
   end

   // configuration registers and base point
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_lat_ff <= '0;
         cfg_lon_ff <= '0;
         cfg_alt_ff <= '0;
         cfg_semi_ff <= gte_pkg::SEMI_RESET;
         cfg_ecc_ff <= gte_pkg::ECC_RESET;
         base_lat_ff <= '0;
         base_lon_ff <= '0;
         base_x_ff <= '0;
         base_y_ff <= '0;
         base_z_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               gte_pkg::CSR_REF_LAT: cfg_lat_ff <= csr_data[31:0];
               gte_pkg::CSR_REF_LON: cfg_lon_ff <= csr_data[31:0];
               gte_pkg::CSR_REF_ALT: cfg_alt_ff <= csr_data[27:0];
               gte_pkg::CSR_SEMI:    cfg_semi_ff <= csr_data;
               gte_pkg::CSR_ECC:     cfg_ecc_ff <= csr_data[26:0];
               default: ;
            endcase
         end
         if (state_ff == gte_pkg::ST_PZ && mul_done_ff && is_base) begin
            base_lat_ff <= op_lat_ff;
            base_lon_ff <= op_lon_ff;
            base_x_ff <= 36'(px_ff);
            base_y_ff <= 36'(py_ff);
            base_z_ff <= 36'(res);
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_act_ff <= req_action;
         if (req_action == gte_pkg::ACT_RELOAD) begin
            op_lat_ff <= cfg_lat_ff;
            op_lon_ff <= cfg_lon_ff;
            op_alt_ff <= $signed(cfg_alt_ff);
         end else begin
            op_lat_ff <= req_fix_latitude;
            op_lon_ff <= req_fix_longitude;
            op_alt_ff <= req_fix_altitude;
         end
      end
      if (cor_done) begin
         case (state_ff)
            gte_pkg::ST_LAT, gte_pkg::ST_BLAT: begin
               sl_ff <= cor_sin;
               cl_ff <= cor_cos;
            end
            default: begin
               so_ff <= cor_sin;
               co_ff <= cor_cos;
            end
         endcase
      end
      if (dsu_done) begin
         if (state_ff == gte_pkg::ST_ROOT) w_ff <= dsu_result[31:0];
         else n_ff <= dsu_result[35:0];
      end
      if (mul_done_ff) begin
         case (state_ff)
            gte_pkg::ST_SQ: s2_ff <= mul_p_ff[61:30];
            gte_pkg::ST_TE: t_ff <= mul_p_ff[61:30];
            gte_pkg::ST_NZ: nz_ff <= n_ff - p_r32[67:32];
            gte_pkg::ST_RC: rc_ff <= 41'(res);
            gte_pkg::ST_PX: px_ff <= 37'(res);
            gte_pkg::ST_PY: py_ff <= 37'(res);
            gte_pkg::ST_PZ: begin
               acc_ff <= res;
               east_ff <= '0;
               north_ff <= '0;
               up_ff <= '0;
            end
            gte_pkg::ST_XC: begin
               acc_ff <= res;
               nz_ff <= 36'(dz);
            end
            gte_pkg::ST_YS: r_ff <= 41'(acc_ff + res);
            gte_pkg::ST_YC: acc_ff <= res;
            gte_pkg::ST_XS: east_ff <= gte_pkg::sat_out(48'(acc_ff) - 48'(res));
            gte_pkg::ST_ZC: acc_ff <= res;
            gte_pkg::ST_RS: north_ff <= gte_pkg::sat_out(48'(acc_ff) - 48'(res));
            gte_pkg::ST_ZS: acc_ff <= res;
            gte_pkg::ST_RCL: up_ff <= gte_pkg::sat_out(48'(acc_ff) + 48'(res));
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == gte_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == gte_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_east_ff <= east_ff;
         rsp_north_ff <= north_ff;
         rsp_up_ff <= up_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_east = rsp_east_ff;
   assign rsp_north = rsp_north_ff;
   assign rsp_up = rsp_up_ff;

endmodule

// File: sv/gte_cordic.sv
// ----------------------------------------------------------------------------
// gte_cordic
// iterative rotation cordic, one micro-rotation per cycle, q30 sine and cosine
// ----------------------------------------------------------------------------
module gte_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [31:0]         angle,
   output logic                done,
   output logic signed [32:0]  sin_out,
   output logic signed [32:0]  cos_out
);

   logic busy_ff, done_ff, flip_ff;
   logic [gte_pkg::STEP_W-1:0] idx_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic signed [33:0] xs, ys, at;
   logic flip_a;
   logic [31:0] ang_t;
   logic last;

   always_comb begin
      flip_a = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
      ang_t = flip_a ? angle + 32'h8000_0000 : angle;
      xs = x_ff >>> idx_ff;
      ys = y_ff >>> idx_ff;
      at = $signed({4'b0, gte_pkg::atan_bam(6'(idx_ff))});
      last = idx_ff == gte_pkg::STEP_W'(gte_pkg::CORDIC_STEPS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            idx_ff <= '0;
         end else if (busy_ff) begin
            idx_ff <= idx_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= gte_pkg::CORDIC_GAIN;
         y_ff <= '0;
         z_ff <= 34'($signed(ang_t));
         flip_ff <= flip_a;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
   end

   assign done = done_ff;
   assign sin_out = 33'(flip_ff ? -y_ff : y_ff);
   assign cos_out = 33'(flip_ff ? -x_ff : x_ff);

endmodule

// File: sv/gte_dsu.sv
// ----------------------------------------------------------------------------
// gte_dsu
// shift and subtract unit: bit-serial square root or restoring division
// ----------------------------------------------------------------------------
module gte_dsu (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  gte_pkg::dsu_op_type op,
   input  logic [63:0]         arg,
   input  logic [31:0]         divisor,
   output logic                done,
   output logic [63:0]         result
);

   logic busy_ff, done_ff;
   gte_pkg::dsu_op_type op_ff;
   logic [5:0] cnt_ff;
   logic [63:0] v_ff, r_ff, sq_bit_ff;
   logic [31:0] rem_ff, d_ff;
   logic [63:0] sum;
   logic [32:0] trial;
   logic ge;
   logic last;

   always_comb begin
      sum = r_ff + sq_bit_ff;
      trial = {rem_ff, v_ff[63]};
      ge = trial >= {1'b0, d_ff};
      last = (op_ff == gte_pkg::DSU_SQRT) ? (cnt_ff == 6'd31) : (cnt_ff == 6'd63);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff <= op;
         v_ff <= arg;
         r_ff <= '0;
         sq_bit_ff <= 64'h4000_0000_0000_0000;
         rem_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         case (op_ff)
            gte_pkg::DSU_SQRT: begin
               if (v_ff >= sum) begin
                  v_ff <= v_ff - sum;
                  r_ff <= (r_ff >> 1) + sq_bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
            end
            default: begin
               rem_ff <= ge ? 32'(trial - {1'b0, d_ff}) : trial[31:0];
               v_ff <= v_ff << 1;
               r_ff <= {r_ff[62:0], ge};
            end
         endcase
      end
   end

   assign done = done_ff;
   assign result = r_ff;

endmodule
